### rtl/core/uart_register_stub_with_console_line_assert.svh
`ifndef UART_REGISTER_STUB_WITH_CONSOLE_LINE_ASSERT_SVH
`define UART_REGISTER_STUB_WITH_CONSOLE_LINE_ASSERT_SVH

// condition holds at every edge out of reset
`define UARTC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define UARTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/uartc_pkg.sv
package uartc_pkg;

    localparam int REG_COUNT      = 15;
    localparam int REG_IDX_W      = 4;
    localparam int LINE_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [11:0]          BLOCK_SIZE = 12'h03C;
    localparam logic [REG_IDX_W-1:0] TX_INDEX   = 4'd8;
    localparam logic [7:0]           ESC_CHAR   = 8'h1B;
    localparam logic [7:0]           END_ESC    = 8'h6D;
    localparam logic [7:0]           NEWLINE    = 8'h0A;

    localparam logic [1:0] KIND_RESP = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [31:0] RESET_TABLE [REG_COUNT] = '{
        32'h00000003, 32'h000003c5, 32'h00000111, 32'h00000000,
        32'h00000002, 32'h00000000, 32'h00010000, 32'h00000011,
        32'h00000000, 32'h00000000, 32'h00000021, 32'h0000000b,
        32'h00000004, 32'h00000004, 32'h00000000
    };

    // one classified access handed from front to back
    typedef struct packed {
        logic [31:0] rdata;
        logic        oor;
        logic        is_tx;
        logic [7:0]  ch;
    } entry_t;

endpackage

### rtl/core/uartc_front.sv
module uartc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [11:0]          byte_offset,
    input  logic [31:0]          write_data,
    input  logic [31:0]          write_mask,
    input  logic                 q_full,
    output logic                 q_push,
    output uartc_pkg::entry_t    q_entry
);

    logic [31:0]                     regs_reg [uartc_pkg::REG_COUNT];
    logic [uartc_pkg::REG_IDX_W-1:0] idx;
    logic                            oor;
    logic                            wr_en;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign oor      = (byte_offset >= uartc_pkg::BLOCK_SIZE);
    assign idx      = byte_offset[uartc_pkg::REG_IDX_W+1:2];
    assign wr_en    = q_push && command && !oor;

    always_comb
    begin
        q_entry.oor   = oor;
        q_entry.is_tx = command && !oor && (idx == uartc_pkg::TX_INDEX);
        q_entry.ch    = write_data[7:0];
        q_entry.rdata = (!command && !oor) ? regs_reg[idx] : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uartc_pkg::REG_COUNT; i++)
            begin
                regs_reg[i] <= uartc_pkg::RESET_TABLE[i];
            end
        end
        else if (wr_en)
        begin
            regs_reg[idx] <= (regs_reg[idx] & ~write_mask) | (write_data & write_mask);
        end
    end

endmodule

### rtl/core/uartc_queue.sv
module uartc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  uartc_pkg::entry_t    push_data,
    output logic                 full,
    output logic                 valid,
    input  logic                 pop,
    output uartc_pkg::entry_t    pop_data
);

    localparam int PTR_W = (uartc_pkg::QUEUE_DEPTH > 1) ? $clog2(uartc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(uartc_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(uartc_pkg::QUEUE_DEPTH - 1);

    uartc_pkg::entry_t slot_reg [uartc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(uartc_pkg::QUEUE_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/uartc_back.sv
`include "uart_register_stub_with_console_line_assert.svh"

module uartc_back
#(
    parameter int LINE_DEPTH = uartc_pkg::LINE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  uartc_pkg::entry_t    q_entry,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_kind,
    output logic [31:0]          read_data,
    output logic                 out_of_range,
    output logic [7:0]           console_char,
    output logic                 last
);

    localparam int IDX_W  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int FILL_W = $clog2(LINE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(LINE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RESP  = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_CHAR  = 3'd5;
    localparam logic [2:0] S_END   = 3'd6;

    logic [7:0]        line_mem [LINE_DEPTH];
    logic [7:0]        rdata_reg;

    logic [2:0]        state_reg, state_next;
    uartc_pkg::entry_t ent_reg, ent_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic              skip_reg, skip_next;
    logic              final_reg, final_next;

    logic              beat;
    logic              is_nl;
    logic              mem_we;
    logic              mem_re;

    assign is_nl  = (ent_reg.ch == uartc_pkg::NEWLINE);
    assign beat   = out_valid && !out_stall;
    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign mem_we = (state_reg == S_STORE);
    assign mem_re = (state_reg == S_RD);

    always_comb
    begin
        out_valid    = 1'b0;
        result_kind  = uartc_pkg::KIND_RESP;
        read_data    = 32'd0;
        out_of_range = 1'b0;
        console_char = 8'd0;
        last         = 1'b0;
        unique case (state_reg)
            S_RESP:
            begin
                out_valid    = 1'b1;
                read_data    = ent_reg.rdata;
                out_of_range = ent_reg.oor;
                last         = !(ent_reg.is_tx && ((fill_reg == FULL_FILL) || is_nl));
            end
            S_CHAR:
            begin
                out_valid    = 1'b1;
                result_kind  = uartc_pkg::KIND_CHAR;
                console_char = rdata_reg;
            end
            S_END:
            begin
                out_valid   = 1'b1;
                result_kind = uartc_pkg::KIND_END;
                last        = final_reg || !is_nl;
            end
            S_IDLE, S_STORE, S_RD, S_CHK:
            begin
                out_valid = 1'b0;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        skip_next   = skip_reg;
        final_next  = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    ent_next   = q_entry;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (beat)
                begin
                    if (!ent_reg.is_tx)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (fill_reg == FULL_FILL)
                    begin
                        rd_idx_next = '0;
                        skip_next   = 1'b0;
                        final_next  = 1'b0;
                        state_next  = S_RD;
                    end
                    else
                    begin
                        state_next = S_STORE;
                    end
                end
            end
            S_STORE:
            begin
                fill_next = fill_reg + 1'b1;
                if (is_nl)
                begin
                    rd_idx_next = '0;
                    skip_next   = 1'b0;
                    final_next  = 1'b1;
                    state_next  = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = (rd_idx_reg >= fill_reg) ? S_END : S_CHK;
            end
            S_CHK:
            begin
                if (skip_reg)
                begin
                    if (rdata_reg == uartc_pkg::END_ESC)
                    begin
                        skip_next = 1'b0;
                    end
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = S_RD;
                end
                else if (rdata_reg == uartc_pkg::ESC_CHAR)
                begin
                    skip_next   = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = S_RD;
                end
                else
                begin
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (beat)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = S_RD;
                end
            end
            S_END:
            begin
                if (beat)
                begin
                    fill_next  = '0;
                    state_next = final_reg ? S_IDLE : S_STORE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            rd_idx_reg <= '0;
            skip_reg   <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            rd_idx_reg <= rd_idx_next;
            skip_reg   <= skip_next;
            final_reg  <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[fill_reg[IDX_W-1:0]] <= ent_reg.ch;
        end
        if (mem_re)
        begin
            rdata_reg <= line_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    `UARTC_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FULL_FILL, "line fill above depth")
    `UARTC_ASSERT_ALWAYS(a_store_room, (state_reg != S_STORE) || (fill_reg < FULL_FILL),
        "store into full line buffer")
    `UARTC_ASSERT_NEXT(a_end_clears, (state_reg == S_END) && beat, fill_reg == '0,
        "line fill not cleared after end marker")
    `UARTC_ASSERT_ALWAYS(a_rd_bound, (state_reg != S_CHK) || (rd_idx_reg < fill_reg),
        "drain check past line fill")

endmodule

### rtl/core/uart_register_stub_with_console_line.sv
// channel  | handshake             | beat carries
// ---------+-----------------------+------------------------------------------------------
// in       | in_valid / in_stall   | command, byte_offset, write_data, write_mask
// out      | out_valid / out_stall | result_kind, read_data, out_of_range, console_char, last
//
// An access response is registered in the queue slot, then in the back end's entry register; the
// back end pops and responds for a read, an out-of-range access or a plain write, and a transmit
// write also stores its character. A line drain reads the line buffer and checks each buffered
// character, plus an output beat for each one it emits, then a final read and the end-marker beat.
// Reset loads the register table and empties the line; the line buffer itself is not cleared.
// in_stall rises only when the two-entry queue is full; out_stall holds the back end in place.
module uart_register_stub_with_console_line
#(
    parameter int LINE_DEPTH = uartc_pkg::LINE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [11:0] byte_offset,
    input  logic [31:0] write_data,
    input  logic [31:0] write_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] read_data,
    output logic        out_of_range,
    output logic [7:0]  console_char,
    output logic        last
);

    uartc_pkg::entry_t push_entry;
    uartc_pkg::entry_t pop_entry;
    logic              q_full;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;

    uartc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .byte_offset (byte_offset),
        .write_data  (write_data),
        .write_mask  (write_mask),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    uartc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (pop_entry)
    );

    uartc_back
    #(
        .LINE_DEPTH (LINE_DEPTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (pop_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .read_data    (read_data),
        .out_of_range (out_of_range),
        .console_char (console_char),
        .last         (last)
    );

endmodule

### tb/tb_uart_register_stub_with_console_line.sv
module tb_uart_register_stub_with_console_line;

    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;
        logic        oor;
        logic [7:0]  ch;
        logic        last;
    } console_beat_t;

    class access_scoreboard;
        logic [31:0]   regs [uartc_pkg::REG_COUNT];
        logic [7:0]    line_chars [uartc_pkg::LINE_DEPTH_DEF];
        int unsigned   line_fill;
        console_beat_t expected_beats [$];
        console_beat_t batch [$];
        int            errors;

        function new();
            foreach (regs[i])
                regs[i] = uartc_pkg::RESET_TABLE[i];
            line_fill = 0;
            errors = 0;
        endfunction

        function void add_beat(logic [1:0] kind, logic [31:0] data, logic oor, logic [7:0] ch);
            batch.push_back(console_beat_t'{kind: kind, data: data, oor: oor, ch: ch,
                                            last: 1'b0});
        endfunction

        // emit buffered text, dropping ESC ... 'm' sequences
        function void drain_line();
            int unsigned i;
            i = 0;
            while (i < line_fill)
            begin
                if (line_chars[i] != uartc_pkg::ESC_CHAR)
                begin
                    add_beat(uartc_pkg::KIND_CHAR, 32'h0, 1'b0, line_chars[i]);
                    i++;
                end
                else
                begin
                    while (i < line_fill && line_chars[i] != uartc_pkg::END_ESC)
                        i++;
                    i++;
                end
            end
            add_beat(uartc_pkg::KIND_END, 32'h0, 1'b0, 8'h00);
            line_fill = 0;
        endfunction

        function void note_access(logic cmd, logic [11:0] off, logic [31:0] data,
                                  logic [31:0] mask);
            logic [9:0] idx;
            idx = off[11:2];
            batch.delete();
            if (off >= uartc_pkg::BLOCK_SIZE)
            begin
                add_beat(uartc_pkg::KIND_RESP, 32'h0, 1'b1, 8'h00);
            end
            else if (!cmd)
            begin
                add_beat(uartc_pkg::KIND_RESP, regs[idx], 1'b0, 8'h00);
            end
            else
            begin
                regs[idx] = (regs[idx] & ~mask) | (data & mask);
                add_beat(uartc_pkg::KIND_RESP, 32'h0, 1'b0, 8'h00);
                if (idx == 10'(uartc_pkg::TX_INDEX))
                begin
                    if (line_fill >= uartc_pkg::LINE_DEPTH_DEF)
                        drain_line();
                    line_chars[line_fill] = data[7:0];
                    line_fill++;
                    if (data[7:0] == uartc_pkg::NEWLINE)
                        drain_line();
                end
            end
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                expected_beats.push_back(batch[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [1:0] kind, logic [31:0] data, logic oor,
                                 logic [7:0] ch, logic last);
            console_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d", kind);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(kind));
            compare_field("read_data", want.data, data);
            compare_field("out_of_range", 32'(want.oor), 32'(oor));
            compare_field("console_char", 32'(want.ch), 32'(ch));
            compare_field("last", 32'(want.last), 32'(last));
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [11:0] byte_offset;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [31:0] read_data;
    logic        out_of_range;
    logic [7:0]  console_char;
    logic        last;

    access_scoreboard sb;
    int unsigned      beats_sent;
    logic             calm;
    logic             hold_req;

    uart_register_stub_with_console_line dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .byte_offset  (byte_offset),
        .write_data   (write_data),
        .write_mask   (write_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .read_data    (read_data),
        .out_of_range (out_of_range),
        .console_char (console_char),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_access(input logic cmd, input logic [11:0] off,
                               input logic [31:0] data, input logic [31:0] mask);
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        byte_offset <= off;
        write_data  <= data;
        write_mask  <= mask;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_access(cmd, off, data, mask);
        beats_sent++;
    endtask

    task automatic send_tx(input logic [7:0] ch);
        send_access(1'b1, (12'(uartc_pkg::TX_INDEX) << 2) | 12'($urandom_range(0, 3)),
                    ($urandom & 32'hFFFF_FF00) | 32'(ch), $urandom);
    endtask

    task automatic send_line(input int len, input bit with_newline);
        int n;
        int pick;
        n = 0;
        while (n < len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12 && len - n >= 4)
            begin
                send_tx(uartc_pkg::ESC_CHAR);
                send_tx("[");
                send_tx(8'h30 + 8'($urandom_range(0, 9)));
                send_tx(uartc_pkg::END_ESC);
                n += 4;
            end
            else if (pick < 16)
            begin
                send_tx(uartc_pkg::ESC_CHAR);
                n++;
            end
            else
            begin
                send_tx(8'($urandom_range(8'h20, 8'h7E)));
                n++;
            end
        end
        if (with_newline)
            send_tx(uartc_pkg::NEWLINE);
    endtask

    // result side: check accepted beats, random stalls, one long hold-off
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_beat(result_kind, read_data, out_of_range, console_char, last);
            if (hold_req && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("uart_register_stub_with_console_line: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned target;
        int          pick;
        logic [11:0] off;
        logic [31:0] mask;
        sb = new();
        beats_sent = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= 1'b0;
        byte_offset <= 12'h000;
        write_data  <= 32'h0;
        write_mask  <= 32'h0;
        calm        <= 1'b0;
        hold_req    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, edges of the window, mask extremes, console paths
        send_access(1'b0, 12'h000, 32'h0, 32'h0);
        send_access(1'b0, 12'h03B, 32'h0, 32'h0);
        send_access(1'b0, uartc_pkg::BLOCK_SIZE, 32'h0, 32'h0);
        send_access(1'b0, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(1'b1, uartc_pkg::BLOCK_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(1'b1, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(1'b1, 12'h005, 32'hFFFF_FFFF, 32'h0);
        send_access(1'b0, 12'h004, 32'h0, 32'h0);
        send_access(1'b1, 12'h006, 32'hA5A5_A5A5, 32'hFFFF_0000);
        send_access(1'b0, 12'h007, 32'h0, 32'h0);
        send_access(1'b1, 12'h038, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(1'b0, 12'h038, 32'h0, 32'h0);
        send_tx("H");
        send_tx("i");
        send_tx(uartc_pkg::ESC_CHAR);
        send_tx("[");
        send_tx("3");
        send_tx("1");
        send_tx(uartc_pkg::END_ESC);
        send_tx("!");
        send_tx(uartc_pkg::NEWLINE);
        send_access(1'b0, 12'h021, 32'h0, 32'h0);
        // escape never closed: swallows the rest of the line
        send_tx(uartc_pkg::ESC_CHAR);
        send_tx("x");
        send_tx(uartc_pkg::NEWLINE);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);

        target = beats_sent + 150;
        // full line then newline: drain twice on one access
        send_line(32, 1'b1);
        // overfull line: drain before storing
        send_line(34, 1'b0);
        while (beats_sent < target)
        begin
            if (!hold_req && beats_sent + 100 >= target)
                hold_req <= 1'b1;
            calm <= (beats_sent + 80 >= target) && (beats_sent + 40 < target);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_line($urandom_range(33, 38), 1'($urandom_range(0, 1)));
                else
                    send_line($urandom_range(1, 10), $urandom_range(0, 99) < 80);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    off = 12'($urandom_range(0, 59));
                else if (pick < 60)
                    off = (12'(uartc_pkg::TX_INDEX) << 2) | 12'($urandom_range(0, 3));
                else
                    off = 12'($urandom);
                pick = $urandom_range(0, 3);
                mask = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                send_access(1'($urandom_range(0, 1)), off, $urandom, mask);
            end
        end

        in_valid <= 1'b0;
        calm     <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("uart_register_stub_with_console_line: match");
        else
            $display("uart_register_stub_with_console_line: mismatch");
        $finish;
    end

endmodule

### uart_register_stub_with_console_line.f
+incdir+rtl/core
rtl/core/uartc_pkg.sv
rtl/core/uartc_front.sv
rtl/core/uartc_queue.sv
rtl/core/uartc_back.sv
rtl/core/uart_register_stub_with_console_line.sv
tb/tb_uart_register_stub_with_console_line.sv
